// ----- design/gopr_pkg.sv -----
// ----------------------------------------------------------------------------
// gopr_pkg: shared types and codes of the group reorder buffer
// Command and result layouts, status codes and register indexes.
// ----------------------------------------------------------------------------
package gopr_pkg;

  localparam int unsigned TsW   = 64;
  localparam int unsigned SizeW = 26;
  localparam int unsigned OvhW  = 8;
  localparam int unsigned SpanW = 20;
  localparam int unsigned MtW   = 2;
  localparam int unsigned StW   = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [StW-1:0] ST_DONE    = 3'd0;
  localparam logic [StW-1:0] ST_RELEASE = 3'd1;
  localparam logic [StW-1:0] ST_BADTYPE = 3'd2;
  localparam logic [StW-1:0] ST_NOOPEN  = 3'd3;
  localparam logic [StW-1:0] ST_TOOBIG  = 3'd4;
  localparam logic [StW-1:0] ST_FULL    = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_MAX_GROUP = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_OVERHEAD  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SPAN      = 2'd2;

  typedef enum logic [1:0] {
    OP_KEY,
    OP_ADD,
    OP_BAD,
    OP_FINAL
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [MtW-1:0]         mt;
    logic signed [TsW-1:0]  ts;
    logic [SizeW-1:0]       bytes;
  } cmd_t;

  typedef struct packed {
    logic [SizeW-1:0] max_group;
    logic [OvhW-1:0]  overhead;
    logic [SpanW-1:0] span;
  } cfg_t;

  typedef struct packed {
    logic [StW-1:0]         status;
    logic signed [TsW-1:0]  ts;
    logic [MtW-1:0]         mt;
    logic [SizeW-1:0]       bytes;
    logic                   complete;
    logic                   last;
  } res_t;

endpackage

// ----- design/gopr_fifo.sv -----
// ----------------------------------------------------------------------------
// gopr_fifo: two-entry queue
// Small register queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
module gopr_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end
endmodule

// ----- design/gopr_front.sv -----
// ----------------------------------------------------------------------------
// gopr_front: request intake and classification
// Sorts each request into finalize, bad type, key insert or size add.
// ----------------------------------------------------------------------------
module gopr_front #(
  parameter int unsigned MEDIA_TYPES = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic                           req_type_i,
  input  logic [gopr_pkg::MtW-1:0]       media_type_i,
  input  logic                           key_frame_i,
  input  logic signed [gopr_pkg::TsW-1:0] frame_ts_i,
  input  logic [gopr_pkg::SizeW-1:0]     frame_bytes_i,
  input  logic                           cmd_pop_i,
  output gopr_pkg::cmd_t                 cmd_o,
  output logic                           cmd_empty_o
);
  import gopr_pkg::*;

  cmd_t                 cmd_in;
  logic [$bits(cmd_t)-1:0] cmd_bits;

  always_comb begin
    cmd_in.mt    = media_type_i;
    cmd_in.ts    = frame_ts_i;
    cmd_in.bytes = frame_bytes_i;
    if (req_type_i) cmd_in.op = OP_FINAL;
    else if ({1'b0, media_type_i} >= 3'(MEDIA_TYPES)) cmd_in.op = OP_BAD;
    else if (key_frame_i) cmd_in.op = OP_KEY;
    else cmd_in.op = OP_ADD;
  end

  gopr_fifo #(.WIDTH($bits(cmd_t))) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_bits),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = cmd_t'(cmd_bits);
endmodule

// ----- design/gopr_engine.sv -----
// ----------------------------------------------------------------------------
// gopr_engine: sorted group table and its sequencer
// Inserts, grows, closes and releases group entries one command at a time.
// ----------------------------------------------------------------------------
module gopr_engine #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned CW = $clog2(DEPTH + 1),
  localparam int unsigned IW = $clog2(DEPTH)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gopr_pkg::cfg_t cfg_i,
  input  gopr_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  output logic           res_valid_o,
  output gopr_pkg::res_t res_o,
  input  logic           res_ready_i,
  output logic           idle_o,
  output logic [CW-1:0]  count_o
);
  import gopr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CMP   = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_READ  = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_INS   = 4'd5;
  localparam logic [3:0] S_REL   = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic signed [TsW-1:0] ts_q [DEPTH];
  logic [MtW-1:0]        ty_q [DEPTH];
  logic                  cl_q [DEPTH];
  logic [SizeW-1:0]      sz_q [DEPTH];

  logic [3:0]            state_q;
  logic [CW-1:0]         cnt_q;
  logic [IW-1:0]         idx_q;
  logic [DEPTH-1:0]      gt_q, hit_q;
  logic [StW-1:0]        status_q;
  logic signed [TsW-1:0] hi_q;
  cmd_t                  cmd_q;
  logic [SizeW-1:0]      key_sz_q;
  logic [SizeW+1:0]      sum_q;

  logic [SizeW:0]        key_sum;
  logic [TsW-1:0]        span_diff;
  logic                  span_exc, res_fire, do_shift, do_ins, do_add, do_close;

  assign key_sum   = {1'b0, cmd_i.bytes} + {{(SizeW+1-OvhW){1'b0}}, cfg_i.overhead};
  assign span_diff = hi_q - ts_q[0];
  assign span_exc  = (cnt_q >= CW'(2)) && cl_q[0] && (hi_q > ts_q[0]) &&
                     (span_diff > {{(TsW-SpanW){1'b0}}, cfg_i.span});

  assign cmd_pop_o = (state_q == S_IDLE) && !cmd_empty_i;
  assign idle_o    = (state_q == S_IDLE);
  assign count_o   = cnt_q;

  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    unique case (state_q)
      S_REL, S_DRAIN: begin
        if ((state_q == S_REL) ? span_exc : (cnt_q != '0)) begin
          res_valid_o    = 1'b1;
          res_o.status   = ST_RELEASE;
          res_o.ts       = ts_q[0];
          res_o.mt       = ty_q[0];
          res_o.bytes    = sz_q[0];
          res_o.complete = cl_q[0];
        end
      end
      S_DONE: begin
        res_valid_o  = 1'b1;
        res_o.status = status_q;
        res_o.last   = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_fire = res_valid_o && res_ready_i;
  assign do_shift = res_fire && (state_q != S_DONE);
  assign do_ins   = (state_q == S_INS);
  assign do_add   = (state_q == S_CHK) && (sum_q <= {2'b00, cfg_i.max_group});
  assign do_close = (state_q == S_CMP) && (cmd_q.op == OP_KEY);

  // Sequencer and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      idx_q    <= '0;
      status_q <= ST_DONE;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (!cmd_empty_i) begin
            status_q <= ST_DONE;
            unique case (cmd_i.op)
              OP_FINAL: state_q <= S_DRAIN;
              OP_BAD: begin
                status_q <= ST_BADTYPE;
                state_q  <= S_DONE;
              end
              default: state_q <= S_CMP;
            endcase
          end
        end
        S_CMP: begin
          idx_q <= IW'(cnt_q - CW'(1));
          if (cmd_q.op == OP_KEY) begin
            if (cnt_q == CW'(DEPTH)) begin
              status_q <= ST_FULL;
              state_q  <= S_REL;
            end else begin
              state_q <= S_INS;
            end
          end else if (cnt_q == '0) begin
            status_q <= ST_NOOPEN;
            state_q  <= S_DONE;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit_q[idx_q]) begin
            state_q <= S_READ;
          end else if (idx_q == '0) begin
            status_q <= ST_NOOPEN;
            state_q  <= S_DONE;
          end else begin
            idx_q <= idx_q - IW'(1);
          end
        end
        S_READ: state_q <= S_CHK;
        S_CHK: begin
          if (do_add) begin
            state_q <= S_REL;
          end else begin
            status_q <= ST_TOOBIG;
            state_q  <= S_DONE;
          end
        end
        S_INS: begin
          cnt_q   <= cnt_q + CW'(1);
          state_q <= S_REL;
        end
        S_REL: begin
          if (!span_exc) state_q <= S_DONE;
          else if (res_fire) cnt_q <= cnt_q - CW'(1);
        end
        S_DRAIN: begin
          if (cnt_q == '0) state_q <= S_DONE;
          else if (res_fire) cnt_q <= cnt_q - CW'(1);
        end
        S_DONE: begin
          if (res_fire) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers and the entry table.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q    <= cmd_i;
      key_sz_q <= key_sum[SizeW] ? '1 : key_sum[SizeW-1:0];
    end
    if (state_q == S_CMP) begin
      for (int i = 0; i < DEPTH; i++) begin
        gt_q[i]  <= (CW'(i) < cnt_q) && (ts_q[i] > cmd_q.ts);
        hit_q[i] <= (CW'(i) < cnt_q) && (ty_q[i] == cmd_q.mt) && !cl_q[i];
      end
    end
    if (state_q == S_READ) begin
      sum_q <= {2'b00, sz_q[idx_q]} + {2'b00, cmd_q.bytes} +
               {{(SizeW+2-OvhW){1'b0}}, cfg_i.overhead};
    end
    if (do_ins && ((cnt_q == '0) || (cmd_q.ts >= hi_q))) hi_q <= cmd_q.ts;

    for (int i = 0; i < DEPTH; i++) begin
      if (do_close && (ty_q[i] == cmd_q.mt)) cl_q[i] <= 1'b1;
      if (do_add && (IW'(i) == idx_q)) sz_q[i] <= sum_q[SizeW-1:0];
      if (do_ins) begin
        if ((i > 0) && gt_q[(i > 0) ? i - 1 : 0]) begin
          ts_q[i] <= ts_q[(i > 0) ? i - 1 : 0];
          ty_q[i] <= ty_q[(i > 0) ? i - 1 : 0];
          cl_q[i] <= cl_q[(i > 0) ? i - 1 : 0];
          sz_q[i] <= sz_q[(i > 0) ? i - 1 : 0];
        end else if (gt_q[i] || (CW'(i) == cnt_q)) begin
          ts_q[i] <= cmd_q.ts;
          ty_q[i] <= cmd_q.mt;
          cl_q[i] <= 1'b0;
          sz_q[i] <= key_sz_q;
        end
      end
      if (do_shift && (i < DEPTH - 1)) begin
        ts_q[i] <= ts_q[(i < DEPTH - 1) ? i + 1 : i];
        ty_q[i] <= ty_q[(i < DEPTH - 1) ? i + 1 : i];
        cl_q[i] <= cl_q[(i < DEPTH - 1) ? i + 1 : i];
        sz_q[i] <= sz_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end
endmodule

// ----- design/gop_reorder_buffer.sv -----
// ----------------------------------------------------------------------------
// gop_reorder_buffer: timestamp-sorted buffer of group descriptors
// Front queue, table sequencer and result queue of the group reorder buffer.
// ----------------------------------------------------------------------------
// A request's closing result follows the group releases that it causes. The sequencer
// takes one command at a time; a further request waits in the front queue meanwhile.
// A size add scans the table one entry per cycle, from the last entry down to the
// first, and each release waits while the result queue is full.
// Reset: asynchronous, active low; empties all queues and the table and
// loads the register defaults. No clearing pass is needed.
module gop_reorder_buffer #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned MEDIA_TYPES = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request channel.
  input  logic                            push,
  output logic                            full,
  input  logic                            req_type_i,
  input  logic [gopr_pkg::MtW-1:0]        media_type_i,
  input  logic                            key_frame_i,
  input  logic signed [gopr_pkg::TsW-1:0] frame_ts_i,
  input  logic [gopr_pkg::SizeW-1:0]      frame_bytes_i,
  // Result channel.
  output logic                            empty,
  input  logic                            pop,
  output logic [gopr_pkg::StW-1:0]        status_o,
  output logic signed [gopr_pkg::TsW-1:0] group_ts_o,
  output logic [gopr_pkg::MtW-1:0]        group_media_type_o,
  output logic [gopr_pkg::SizeW-1:0]      group_bytes_o,
  output logic                            group_complete_o,
  output logic                            last_o,
  // Register write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gopr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [gopr_pkg::SizeW-1:0]      cfg_data_i
);
  import gopr_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  cfg_t  cfg_q;
  cmd_t  cmd;
  logic  cmd_empty, cmd_pop;
  res_t  eng_res, out_res;
  logic  eng_res_valid, out_full, eng_idle;
  logic [CW-1:0] eng_count;
  logic [$bits(res_t)-1:0] out_bits;

  // Register writes are taken only while the sequencer is idle and no request
  // waits in the front queue, so no transaction sees a register change midway.
  assign cfg_ready_o = eng_idle && cmd_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_group <= 26'd52428800;
      cfg_q.overhead  <= 8'd16;
      cfg_q.span      <= 20'd20000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MAX_GROUP: cfg_q.max_group <= cfg_data_i;
        REG_OVERHEAD:  cfg_q.overhead  <= cfg_data_i[OvhW-1:0];
        REG_SPAN:      cfg_q.span      <= cfg_data_i[SpanW-1:0];
        default: ;
      endcase
    end
  end

  // The front queue classifies each request so the sequencer can branch at once.
  gopr_front #(.MEDIA_TYPES(MEDIA_TYPES)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .req_type_i    (req_type_i),
    .media_type_i  (media_type_i),
    .key_frame_i   (key_frame_i),
    .frame_ts_i    (frame_ts_i),
    .frame_bytes_i (frame_bytes_i),
    .cmd_pop_i     (cmd_pop),
    .cmd_o         (cmd),
    .cmd_empty_o   (cmd_empty)
  );

  gopr_engine #(.DEPTH(DEPTH)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (eng_res_valid),
    .res_o       (eng_res),
    .res_ready_i (!out_full),
    .idle_o      (eng_idle),
    .count_o     (eng_count)
  );

  // The result queue lets the table keep working while results wait.
  gopr_fifo #(.WIDTH($bits(res_t))) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (eng_res_valid),
    .data_i  (eng_res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_bits),
    .empty_o (empty)
  );

  assign out_res            = res_t'(out_bits);
  assign status_o           = out_res.status;
  assign group_ts_o         = out_res.ts;
  assign group_media_type_o = out_res.mt;
  assign group_bytes_o      = out_res.bytes;
  assign group_complete_o   = out_res.complete;
  assign last_o             = out_res.last;

  // The table never holds more groups than it has entries.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_count <= CW'(DEPTH)) else $error("group table overfilled");

  // A closing result that enters the result queue returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_res_valid && !out_full && eng_res.last |=> eng_idle)
    else $error("sequencer busy after closing result");

  // Release results always carry the release status and never the last mark.
  a_release_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_res_valid && !eng_res.last |-> eng_res.status == ST_RELEASE)
    else $error("malformed release result");
endmodule
